/* rtl/tmc_pkg.sv */
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants for the tracker mode controller.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int unsigned LIGHT_W  = 10;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned TOD_W    = 11;
    localparam int unsigned CONF_W   = 16;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LIGHT_W-1:0] READING_MIN   = 10'd21;
    localparam logic [LIGHT_W-1:0] READING_MAX   = 10'd999;
    localparam logic [6:0]         MIN_PER_HOUR  = 7'd60;
    localparam logic [3:0]         SAMPLES_PER_S = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_TRACKING = 3'd1,
        MODE_CLOUD    = 3'd2,
        MODE_NIGHT    = 3'd3,
        MODE_FAULT    = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOUD_ENTRY = 3'd0,
        CFG_CLOUD_EXIT  = 3'd1,
        CFG_CONFIRM     = 3'd2,
        CFG_NIGHT_START = 3'd3,
        CFG_NIGHT_END   = 3'd4
    } cfg_index_t;

endpackage

/* rtl/tracker_mode_controller_core.sv */
// ----------------------------------------------------------------------------
// tracker_mode_controller_core
// Mode controller for a two-sensor light tracker, one result per sample.
// Each sample passes through the input register and then the result register.
// Throughput: one sample per cycle while the result is taken; input register frees as the result moves on.
// Reset (aresetn, synchronous): mode init, low-sample count and all settings zero.
// ----------------------------------------------------------------------------
module tracker_mode_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tmc_pkg::LIGHT_W-1:0]       s_east_light,
    input  logic [tmc_pkg::LIGHT_W-1:0]       s_west_light,
    input  logic [tmc_pkg::HOUR_W-1:0]        s_hour_of_day,
    input  logic [tmc_pkg::MINUTE_W-1:0]      s_minute_of_hour,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_mode,
    output logic                              m_mode_changed
);

    logic [tmc_pkg::LIGHT_W-1:0]  cloud_entry_reg;
    logic [tmc_pkg::LIGHT_W-1:0]  cloud_exit_reg;
    logic [tmc_pkg::CONF_W-1:0]   confirm_reg;
    logic [tmc_pkg::TOD_W-1:0]    night_start_reg;
    logic [tmc_pkg::TOD_W-1:0]    night_end_reg;

    logic                         in_valid_reg;
    logic [tmc_pkg::LIGHT_W-1:0]  east_reg;
    logic [tmc_pkg::LIGHT_W-1:0]  west_reg;
    logic [tmc_pkg::HOUR_W-1:0]   hour_reg;
    logic [tmc_pkg::MINUTE_W-1:0] minute_reg;

    tmc_pkg::mode_t               mode_reg, mode_next;
    logic [tmc_pkg::COUNT_W-1:0]  low_count_reg, low_count_next;

    logic                         out_valid_reg;
    logic [2:0]                   out_mode_reg;
    logic                         out_changed_reg;

    logic                         out_free;
    logic                         advance;
    logic [tmc_pkg::TOD_W-1:0]    tod;
    logic [tmc_pkg::LIGHT_W:0]    light_sum;
    logic [tmc_pkg::LIGHT_W-1:0]  level;
    logic [tmc_pkg::COUNT_W-1:0]  need;
    logic [tmc_pkg::COUNT_W-1:0]  count_inc;
    logic                         night_window;
    logic                         readings_ok;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid        = out_valid_reg;
    assign m_mode         = out_mode_reg;
    assign m_mode_changed = out_changed_reg;

    // settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cloud_entry_reg <= '0;
            cloud_exit_reg  <= '0;
            confirm_reg     <= '0;
            night_start_reg <= '0;
            night_end_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tmc_pkg::CFG_CLOUD_ENTRY: cloud_entry_reg <= cfg_wr_data[tmc_pkg::LIGHT_W-1:0];
                tmc_pkg::CFG_CLOUD_EXIT:  cloud_exit_reg  <= cfg_wr_data[tmc_pkg::LIGHT_W-1:0];
                tmc_pkg::CFG_CONFIRM:     confirm_reg     <= cfg_wr_data[tmc_pkg::CONF_W-1:0];
                tmc_pkg::CFG_NIGHT_START: night_start_reg <= cfg_wr_data[tmc_pkg::TOD_W-1:0];
                tmc_pkg::CFG_NIGHT_END:   night_end_reg   <= cfg_wr_data[tmc_pkg::TOD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            east_reg   <= s_east_light;
            west_reg   <= s_west_light;
            hour_reg   <= s_hour_of_day;
            minute_reg <= s_minute_of_hour;
        end
    end

    // sample evaluation
    always_comb begin
        tod       = tmc_pkg::TOD_W'(hour_reg) * tmc_pkg::TOD_W'(tmc_pkg::MIN_PER_HOUR)
                    + tmc_pkg::TOD_W'(minute_reg);
        light_sum = {1'b0, east_reg} + {1'b0, west_reg};
        level     = light_sum[tmc_pkg::LIGHT_W:1];
        need      = tmc_pkg::COUNT_W'(confirm_reg)
                    * tmc_pkg::COUNT_W'(tmc_pkg::SAMPLES_PER_S);
        count_inc = (low_count_reg < tmc_pkg::COUNT_MAX) ? low_count_reg + 1'b1 : low_count_reg;

        if (night_start_reg >= night_end_reg) begin
            night_window = (tod >= night_start_reg) || (tod < night_end_reg);
        end else begin
            night_window = (tod >= night_start_reg) && (tod < night_end_reg);
        end

        readings_ok = (east_reg >= tmc_pkg::READING_MIN) && (east_reg <= tmc_pkg::READING_MAX) &&
                      (west_reg >= tmc_pkg::READING_MIN) && (west_reg <= tmc_pkg::READING_MAX);

        mode_next      = mode_reg;
        low_count_next = low_count_reg;
        if (night_window) begin
            mode_next      = tmc_pkg::MODE_NIGHT;
            low_count_next = '0;
        end else if (!readings_ok) begin
            mode_next      = tmc_pkg::MODE_FAULT;
            low_count_next = '0;
        end else begin
            unique case (mode_reg)
                tmc_pkg::MODE_INIT, tmc_pkg::MODE_NIGHT, tmc_pkg::MODE_FAULT: begin
                    mode_next      = tmc_pkg::MODE_TRACKING;
                    low_count_next = '0;
                end
                tmc_pkg::MODE_CLOUD: begin
                    if (level >= cloud_exit_reg) begin
                        mode_next      = tmc_pkg::MODE_TRACKING;
                        low_count_next = '0;
                    end
                end
                tmc_pkg::MODE_TRACKING: begin
                    if (level <= cloud_entry_reg) begin
                        if (count_inc >= need) begin
                            mode_next      = tmc_pkg::MODE_CLOUD;
                            low_count_next = '0;
                        end else begin
                            low_count_next = count_inc;
                        end
                    end else begin
                        low_count_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // mode state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= tmc_pkg::MODE_INIT;
            low_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg      <= mode_next;
                low_count_reg <= low_count_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mode_reg    <= mode_next;
            out_changed_reg <= (mode_next != mode_reg);
        end
    end

    // checks
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_mode_reg == mode_reg))
        else $error("result mode differs from held mode");

    a_count_only_tracking: assert property (@(posedge aclk) disable iff (!aresetn)
        (low_count_reg != '0) |-> (mode_reg == tmc_pkg::MODE_TRACKING))
        else $error("low-sample count held outside tracking");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("request refused with free space");

    a_cloud_from_tracking: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_next == tmc_pkg::MODE_CLOUD && mode_reg != tmc_pkg::MODE_CLOUD)
        |-> (mode_reg == tmc_pkg::MODE_TRACKING))
        else $error("cloud hold entered from a mode other than tracking");

endmodule
